>>> hdl/bfhp_pkg.sv
// Shared types and constants for the bit-file header parser.
// Used by bfhp_core, bfhp_outq and bitstream_file_header_parser_top.
`default_nettype none

package bfhp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned HDR_LEN_W = 20;
    localparam int unsigned BLEN_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned FID_W     = 2;
    localparam int unsigned TAG_W     = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 20;

    // parse_status codes
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // error_kind codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MAGIC   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_VERSION = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TAG     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_STRING  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_LONG    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EVEN_MAGIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ODD_MAGIC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HDR    = 2'd2;

    localparam logic [BYTE_W-1:0]    RST_EVEN_MAGIC = 8'h0F;
    localparam logic [BYTE_W-1:0]    RST_ODD_MAGIC  = 8'hF0;
    localparam logic [CFG_DAT_W-1:0] RST_MAX_HDR    = 20'd4096;

    localparam logic [WORD_W-1:0] VERSION_WORD = 16'h0001;
    localparam logic [BYTE_W-1:0] CHAR_A       = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [TAG_W-1:0]  TAG_E_INDEX  = 3'd4;   // tag 'e'
    localparam logic [WORD_W-1:0] BLEN_BYTES   = 16'd4;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_MAGLEN_HI = 4'd1,
        PH_MAGLEN_LO = 4'd2,
        PH_MAGIC     = 4'd3,
        PH_PAD       = 4'd4,
        PH_VER_HI    = 4'd5,
        PH_VER_LO    = 4'd6,
        PH_TAG       = 4'd7,
        PH_LEN_HI    = 4'd8,
        PH_LEN_LO    = 4'd9,
        PH_STRING    = 4'd10,
        PH_BLEN      = 4'd11,
        PH_DONE      = 4'd12,
        PH_ERROR     = 4'd13
    } t_phase;

    typedef struct packed {
        logic [BLEN_W-1:0]    bitstream_length;
        logic [HDR_LEN_W-1:0] header_length;
        logic                 field_last;
        logic                 field_byte_valid;
        logic [BYTE_W-1:0]    field_byte;
        logic [FID_W-1:0]     field_id;
        logic [ERR_W-1:0]     error_kind;
        logic [STATUS_W-1:0]  parse_status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/bfhp_core.sv
// Header parser state machine and configuration registers.
// Computes one result per accepted byte; depends on bfhp_pkg.
`default_nettype none

module bfhp_core #(
    parameter int unsigned COUNT_WIDTH = 20
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_accept,
    input  wire  [bfhp_pkg::BYTE_W-1:0]      i_byte,
    input  wire                              i_sof,
    input  wire                              i_cfg_we,
    input  wire  [bfhp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bfhp_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    output bfhp_pkg::t_result                o_result
);
    import bfhp_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_DAT_W) ? COUNT_WIDTH : CFG_DAT_W;

    logic [BYTE_W-1:0]      r_even_magic;
    logic [BYTE_W-1:0]      r_odd_magic;
    logic [CFG_DAT_W-1:0]   r_max_hdr;

    t_phase                 r_phase,  n_phase;
    logic [COUNT_WIDTH-1:0] r_cnt,    n_cnt;
    logic [WORD_W-1:0]      r_rem,    n_rem;
    logic                   r_par,    n_par;
    logic [TAG_W-1:0]       r_tag,    n_tag;
    logic [BLEN_W-1:0]      r_acc,    n_acc;
    logic [ERR_W-1:0]       r_err,    n_err;

    // state as seen by this byte, after a possible restart
    t_phase                 e_phase;
    logic [COUNT_WIDTH-1:0] e_cnt;
    logic [WORD_W-1:0]      e_rem;
    logic                   e_par;
    logic [TAG_W-1:0]       e_tag;
    logic [BLEN_W-1:0]      e_acc;
    logic [ERR_W-1:0]       e_err;

    logic                   active;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   too_long;
    logic [WORD_W-1:0]      word;
    logic [WORD_W-1:0]      rem_dec;
    logic [BYTE_W-1:0]      magic_exp;
    logic [BYTE_W-1:0]      tag_exp;
    logic                   string_hit;

    assign e_phase = i_sof ? PH_MAGLEN_HI : r_phase;
    assign e_cnt   = i_sof ? '0 : r_cnt;
    assign e_rem   = i_sof ? '0 : r_rem;
    assign e_par   = i_sof ? 1'b0 : r_par;
    assign e_tag   = i_sof ? '0 : r_tag;
    assign e_acc   = i_sof ? '0 : r_acc;
    assign e_err   = i_sof ? ERR_NONE : r_err;

    assign active = (e_phase != PH_IDLE) && (e_phase != PH_DONE) && (e_phase != PH_ERROR);
    // count saturates at all ones
    assign cnt_inc   = (e_cnt != '1) ? e_cnt + 1'b1 : e_cnt;
    assign too_long  = CMP_W'(cnt_inc) > CMP_W'(r_max_hdr);
    assign word      = {e_acc[BYTE_W-1:0], i_byte};
    assign rem_dec   = e_rem - 1'b1;
    assign magic_exp = e_par ? r_odd_magic : r_even_magic;
    assign tag_exp   = CHAR_A + BYTE_W'(e_tag);

    // next state
    always_comb begin
        n_phase = e_phase;
        n_cnt   = e_cnt;
        n_rem   = e_rem;
        n_par   = e_par;
        n_tag   = e_tag;
        n_acc   = e_acc;
        n_err   = e_err;
        if (active) begin
            n_cnt = cnt_inc;
            if (too_long) begin
                n_err   = ERR_LONG;
                n_phase = PH_ERROR;
            end else begin
                case (e_phase)
                    PH_MAGLEN_HI: begin
                        n_acc   = BLEN_W'(i_byte);
                        n_phase = PH_MAGLEN_LO;
                    end
                    PH_MAGLEN_LO: begin
                        if (word == '0) begin
                            n_err   = ERR_MAGIC;
                            n_phase = PH_ERROR;
                        end else begin
                            n_rem   = word - 1'b1;
                            n_par   = 1'b0;
                            n_phase = (word == WORD_W'(1)) ? PH_PAD : PH_MAGIC;
                        end
                    end
                    PH_MAGIC: begin
                        if (i_byte != magic_exp) begin
                            n_err   = ERR_MAGIC;
                            n_phase = PH_ERROR;
                        end else begin
                            n_par = ~e_par;
                            n_rem = rem_dec;
                            if (rem_dec == '0) begin
                                n_phase = PH_PAD;
                            end
                        end
                    end
                    PH_PAD: begin
                        n_phase = PH_VER_HI;
                    end
                    PH_VER_HI: begin
                        n_acc   = BLEN_W'(i_byte);
                        n_phase = PH_VER_LO;
                    end
                    PH_VER_LO: begin
                        if (word != VERSION_WORD) begin
                            n_err   = ERR_VERSION;
                            n_phase = PH_ERROR;
                        end else begin
                            n_tag   = '0;
                            n_phase = PH_TAG;
                        end
                    end
                    PH_TAG: begin
                        if (e_tag > TAG_E_INDEX || i_byte != tag_exp) begin
                            n_err   = ERR_TAG;
                            n_phase = PH_ERROR;
                        end else if (e_tag == TAG_E_INDEX) begin
                            n_acc   = '0;
                            n_rem   = BLEN_BYTES;
                            n_phase = PH_BLEN;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_acc   = BLEN_W'(i_byte);
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (word == '0) begin
                            n_err   = ERR_STRING;
                            n_phase = PH_ERROR;
                        end else begin
                            n_rem   = word;
                            n_phase = PH_STRING;
                        end
                    end
                    PH_STRING: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            if (i_byte != CHAR_NUL) begin
                                n_err   = ERR_STRING;
                                n_phase = PH_ERROR;
                            end else begin
                                n_tag   = e_tag + 1'b1;
                                n_phase = PH_TAG;
                            end
                        end
                    end
                    PH_BLEN: begin
                        n_acc = {e_acc[BLEN_W-BYTE_W-1:0], i_byte};
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_err   = ERR_TAG;
                        n_phase = PH_ERROR;
                    end
                endcase
            end
        end
    end

    assign string_hit = active && !too_long && (e_phase == PH_STRING);

    // result for this byte
    always_comb begin
        o_result = '0;
        if (n_phase == PH_DONE) begin
            o_result.parse_status     = ST_DONE;
            o_result.header_length    = HDR_LEN_W'(n_cnt);
            o_result.bitstream_length = n_acc;
        end else if (n_phase == PH_ERROR) begin
            o_result.parse_status = ST_INVALID;
            o_result.error_kind   = n_err;
        end else begin
            o_result.parse_status = ST_BUSY;
        end
        if (string_hit) begin
            o_result.field_byte_valid = 1'b1;
            o_result.field_id         = e_tag[FID_W-1:0];
            o_result.field_byte       = i_byte;
            o_result.field_last       = (rem_dec == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_magic <= RST_EVEN_MAGIC;
            r_odd_magic  <= RST_ODD_MAGIC;
            r_max_hdr    <= RST_MAX_HDR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EVEN_MAGIC: r_even_magic <= i_cfg_wdata[BYTE_W-1:0];
                CFG_ODD_MAGIC:  r_odd_magic  <= i_cfg_wdata[BYTE_W-1:0];
                CFG_MAX_HDR:    r_max_hdr    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_par   <= 1'b0;
            r_tag   <= '0;
            r_acc   <= '0;
            r_err   <= ERR_NONE;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_par   <= n_par;
            r_tag   <= n_tag;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

    a_error_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_err != ERR_NONE))
        else $error("error phase without an error kind");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0))
        else $error("byte count advanced while idle");

    a_no_string_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.field_byte_valid) |-> (o_result.parse_status != ST_DONE))
        else $error("string byte reported with a complete header");

endmodule

`default_nettype wire

>>> hdl/bfhp_outq.sv
// Two-entry result queue between the parser and the output stream.
// Lets a new byte be taken while a result still waits; depends on bfhp_pkg.
`default_nettype none

module bfhp_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  bfhp_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  wire                i_pop_ready,
    output bfhp_pkg::t_result  o_data
);
    import bfhp_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("result queue pointers disagree with count");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("result pushed into a full queue");

endmodule

`default_nettype wire

>>> hdl/bitstream_file_header_parser_top.sv
// Top level of the bit-file header parser: stream ports, parser and result queue.
// Instantiates bfhp_core and bfhp_outq; depends on bfhp_pkg.
//
// Channel   Dir  Width           Contents
// s_axis    in   tdata 8, tuser 1  one raw file byte; tuser marks start of file
// m_axis    out  tdata 72, tuser 3, tlast  one result per byte
// cfg       in   index 2, data 20  even magic, odd magic, header limit
//
// One byte per clock is accepted while the result queue has room; each byte's result
// is registered in the result queue and is offered on m_axis in order of arrival.
// A two-entry queue keeps input open while one result waits.
// Synchronous active-low reset returns the parser to idle and loads register defaults.
// Input stalls only when two results are held unread.
`default_nettype none

module bitstream_file_header_parser_top #(
    parameter int unsigned COUNT_WIDTH = 20
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire  [7:0]                       i_s_axis_tdata,  // [7:0] data_byte
    input  wire  [0:0]                       i_s_axis_tuser,  // [0] start_of_file
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // [1:0] parse_status, [4:2] error_kind, [12:5] field_byte,
    // [32:13] header_length, [64:33] bitstream_length, [71:65] zero
    output logic [71:0]                      o_m_axis_tdata,
    output logic [2:0]                       o_m_axis_tuser,  // [1:0] field_id, [2] field_byte_valid
    output logic                             o_m_axis_tlast,  // field_last
    input  wire                              i_cfg_we,
    input  wire  [bfhp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bfhp_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);
    import bfhp_pkg::*;

    logic    accept;
    t_result core_result;
    t_result q_result;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    bfhp_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_s_axis_tdata),
        .i_sof      (i_s_axis_tuser[0]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .o_result   (core_result)
    );

    bfhp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (core_result),
        .o_ready    (o_s_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .i_pop_ready(i_m_axis_tready),
        .o_data     (q_result)
    );

    assign o_m_axis_tdata = {7'd0,
                             q_result.bitstream_length,
                             q_result.header_length,
                             q_result.field_byte,
                             q_result.error_kind,
                             q_result.parse_status};
    assign o_m_axis_tuser = {q_result.field_byte_valid, q_result.field_id};
    assign o_m_axis_tlast = q_result.field_last;

endmodule

`default_nettype wire
